FILE: rtl/lss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;

  localparam int Beams         = 1024;
  localparam int AngleMinMdeg  = -180000;
  localparam int AngleStepMdeg = 352;

  localparam int FullTurnMdeg    = 360000;
  localparam int HalfTurnMdeg    = 180000;
  localparam int QuarterTurnMdeg = 90000;
  localparam longint unsigned PiQ30 = 64'd3373259426;

  localparam int RangeW = 16;
  localparam int IdxW   = 10;
  localparam int WinW   = 20;
  localparam int CntW   = 11;
  localparam int SumW   = 27;
  localparam int TrigW  = 16;
  localparam int DivCntW = $clog2(SumW);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Beams - 1);

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgFrontWin = 3'd0;
  localparam cfg_idx_t CfgSideWin  = 3'd1;
  localparam cfg_idx_t CfgOpenWin  = 3'd2;
  localparam cfg_idx_t CfgFrontThr = 3'd3;
  localparam cfg_idx_t CfgOpenThr  = 3'd4;
  localparam cfg_idx_t CfgRangeMin = 3'd5;
  localparam cfg_idx_t CfgRangeMax = 3'd6;

  typedef logic [1:0] beam_state_t;
  localparam beam_state_t StFinite = 2'd0;
  localparam beam_state_t StInf    = 2'd1;

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t SelFront = 2'd0;
  localparam div_sel_t SelSide  = 2'd1;
  localparam div_sel_t SelOpen  = 2'd2;
  localparam div_sel_t SelFar   = 2'd3;

  typedef struct packed {
    logic     push;
    logic     clear;
    logic     load_out;
    logic     div_start;
    div_sel_t div_sel;
  } lss_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_done;
  } lss_sts_t;

  typedef logic signed [TrigW-1:0] trig_tab_t [Beams];

  function automatic logic signed [TrigW-1:0] sine_quad(longint unsigned x);
    longint unsigned r, r2, term, sum, q;
    r    = x * PiQ30 / HalfTurnMdeg;
    r2   = (r * r) >> 30;
    term = r;
    sum  = r;
    term = ((term * r2) >> 30) / 6;   sum = sum - term;
    term = ((term * r2) >> 30) / 20;  sum = sum + term;
    term = ((term * r2) >> 30) / 42;  sum = sum - term;
    term = ((term * r2) >> 30) / 72;  sum = sum + term;
    term = ((term * r2) >> 30) / 110; sum = sum - term;
    term = ((term * r2) >> 30) / 156; sum = sum + term;
    term = ((term * r2) >> 30) / 210; sum = sum - term;
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return TrigW'(q);
  endfunction

  function automatic logic signed [TrigW-1:0] sine_mdeg(longint a);
    longint m;
    logic signed [TrigW-1:0] v;
    m = a % FullTurnMdeg;
    if (m < 0) m = m + FullTurnMdeg;
    if (m <= QuarterTurnMdeg) begin
      v = sine_quad(longint'(m));
    end else if (m <= HalfTurnMdeg) begin
      v = sine_quad(longint'(HalfTurnMdeg - m));
    end else if (m <= HalfTurnMdeg + QuarterTurnMdeg) begin
      v = -sine_quad(longint'(m - HalfTurnMdeg));
    end else begin
      v = -sine_quad(longint'(FullTurnMdeg - m));
    end
    return v;
  endfunction

  function automatic trig_tab_t build_tab(bit is_cos);
    trig_tab_t t;
    longint a;
    for (int i = 0; i < Beams; i++) begin
      a = longint'(AngleMinMdeg) + longint'(i) * longint'(AngleStepMdeg);
      if (is_cos) a = a + QuarterTurnMdeg;
      t[i] = sine_mdeg(a);
    end
    return t;
  endfunction

  localparam trig_tab_t SinTab = build_tab(1'b0);
  localparam trig_tab_t CosTab = build_tab(1'b1);

endpackage
`default_nettype wire

FILE: rtl/lidar_sector_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Beat
// in_      input      range_mm, beam_state, beam_index, last_beam
// out_     output     front_fraction, side_mean, open_fraction, open_mean, open_mean_valid
// cfg_     input      write enable, register index, 20-bit data
//
// Beams are taken one a cycle, while in_ready is high, into a four-stage
// accumulate pipeline (capture, table read, multiply, accumulate). After a last
// beam the input holds through a drain and four divisions on one shared radix-2
// divider. Reset is synchronous and clears accumulators and control.
// A waiting result stalls only the load of the next scan's results, which holds off new beams.
module lidar_sector_statistics_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [lss_pkg::WinW-1:0]   cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [15:0]                in_range_mm,
  input  wire logic [1:0]                 in_beam_state,
  input  wire logic [9:0]                 in_beam_index,
  input  wire logic                       in_last_beam,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [15:0]                     out_front_fraction,
  output logic [15:0]                     out_side_mean,
  output logic [15:0]                     out_open_fraction,
  output logic [15:0]                     out_open_mean,
  output logic                            out_open_mean_valid
);

  lss_pkg::lss_cmd_t cmd;
  lss_pkg::lss_sts_t sts;

  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_in   (in_last_beam),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lss_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_range_mm         (in_range_mm),
    .in_beam_state       (in_beam_state),
    .in_beam_index       (in_beam_index),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_front_fraction  (out_front_fraction),
    .out_side_mean       (out_side_mean),
    .out_open_fraction   (out_open_fraction),
    .out_open_mean       (out_open_mean),
    .out_open_mean_valid (out_open_mean_valid)
  );

endmodule
`default_nettype wire

FILE: rtl/lss_div.sv
`timescale 1ns / 1ps
`default_nettype none
module lss_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [lss_pkg::SumW-1:0]  num,
  input  wire logic [lss_pkg::CntW-1:0]  den,
  output logic                           done,
  output logic [lss_pkg::SumW-1:0]       quot
);

  logic [lss_pkg::CntW-1:0]    rem_r, rem_nxt;
  logic [lss_pkg::SumW-1:0]    quo_r, quo_nxt;
  logic [lss_pkg::DivCntW-1:0] cnt_r;
  logic                        run_r, done_r;
  logic [lss_pkg::CntW:0]      shifted;
  logic                        fits;

  // one quotient bit a cycle, restoring
  always_comb begin
    shifted = {rem_r, quo_r[lss_pkg::SumW-1]};
    fits    = shifted >= {1'b0, den};
    rem_nxt = fits ? lss_pkg::CntW'(shifted - {1'b0, den}) : shifted[lss_pkg::CntW-1:0];
    quo_nxt = {quo_r[lss_pkg::SumW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= lss_pkg::DivCntW'(lss_pkg::SumW - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

FILE: rtl/lss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lss_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire lss_pkg::cfg_idx_t           cfg_index,
  input  wire logic [lss_pkg::WinW-1:0]    cfg_data,
  input  wire logic [lss_pkg::RangeW-1:0]  in_range_mm,
  input  wire logic [1:0]                  in_beam_state,
  input  wire logic [lss_pkg::IdxW-1:0]    in_beam_index,
  input  wire lss_pkg::lss_cmd_t           cmd,
  output lss_pkg::lss_sts_t                sts,
  output logic [15:0]                      out_front_fraction,
  output logic [15:0]                      out_side_mean,
  output logic [15:0]                      out_open_fraction,
  output logic [15:0]                      out_open_mean,
  output logic                             out_open_mean_valid
);

  localparam int RW = lss_pkg::RangeW;
  localparam int IW = lss_pkg::IdxW;
  localparam int CW = lss_pkg::CntW;
  localparam int SW = lss_pkg::SumW;

  logic [lss_pkg::WinW-1:0] front_win_r, side_win_r, open_win_r;
  logic [RW-1:0] front_thr_r, open_thr_r, range_min_r, range_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_win_r <= 20'hFFC00;
      side_win_r  <= 20'hFFC00;
      open_win_r  <= 20'hFFC00;
      front_thr_r <= 16'd500;
      open_thr_r  <= 16'd1000;
      range_min_r <= 16'd120;
      range_max_r <= 16'd12000;
    end else if (cfg_we) begin
      case (cfg_index)
        lss_pkg::CfgFrontWin: front_win_r <= cfg_data;
        lss_pkg::CfgSideWin:  side_win_r  <= cfg_data;
        lss_pkg::CfgOpenWin:  open_win_r  <= cfg_data;
        lss_pkg::CfgFrontThr: front_thr_r <= cfg_data[RW-1:0];
        lss_pkg::CfgOpenThr:  open_thr_r  <= cfg_data[RW-1:0];
        lss_pkg::CfgRangeMin: range_min_r <= cfg_data[RW-1:0];
        lss_pkg::CfgRangeMax: range_max_r <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic in_win(logic [lss_pkg::WinW-1:0] w, logic [IW-1:0] idx);
    return ({1'b0, idx} < (IW+1)'(lss_pkg::Beams)) && (idx >= w[IW-1:0])
           && (idx <= w[2*IW-1:IW]);
  endfunction

  function automatic logic [CW-1:0] win_len(logic [lss_pkg::WinW-1:0] w);
    logic [IW-1:0] s, e;
    logic [CW-1:0] l;
    s = w[IW-1:0];
    e = (w[2*IW-1:IW] > lss_pkg::LastIdx) ? lss_pkg::LastIdx : w[2*IW-1:IW];
    if ({1'b0, s} >= (IW+1)'(lss_pkg::Beams) || s > e) l = '0;
    else l = CW'({1'b0, e} - {1'b0, s} + 1'b1);
    return l;
  endfunction

  // stage 1: beam capture and window tests
  logic s1_v_r, s2_v_r, s3_v_r;
  logic [RW-1:0] s1_r_r, s2_r_r, s3_r_r;
  logic [1:0]    s1_st_r, s2_st_r, s3_st_r;
  logic [IW-1:0] s1_idx_r;
  logic [2:0]    s1_w_r, s2_w_r, s3_w_r;
  logic signed [lss_pkg::TrigW-1:0] cos_r, sin_r;
  logic [lss_pkg::TrigW-2:0] sin_mag;
  logic signed [RW+lss_pkg::TrigW:0] p_front_r;
  logic [RW+lss_pkg::TrigW-2:0]      p_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.push;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign sin_mag = sin_r[lss_pkg::TrigW-1] ? (lss_pkg::TrigW-1)'(-sin_r)
                                           : sin_r[lss_pkg::TrigW-2:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      s1_r_r   <= in_range_mm;
      s1_st_r  <= in_beam_state;
      s1_idx_r <= in_beam_index;
      s1_w_r   <= {in_win(open_win_r, in_beam_index), in_win(side_win_r, in_beam_index),
                   in_win(front_win_r, in_beam_index)};
    end
    // table read, registered
    s2_r_r  <= s1_r_r;
    s2_st_r <= s1_st_r;
    s2_w_r  <= s1_w_r;
    cos_r   <= lss_pkg::CosTab[s1_idx_r];
    sin_r   <= lss_pkg::SinTab[s1_idx_r];
    // projections
    s3_r_r    <= s2_r_r;
    s3_st_r   <= s2_st_r;
    s3_w_r    <= s2_w_r;
    p_front_r <= $signed({1'b0, s2_r_r}) * cos_r;
    p_side_r  <= s2_r_r * sin_mag;
  end

  assign sts.pipe_busy = s1_v_r | s2_v_r | s3_v_r;

  // stage 4: accumulate
  logic [CW-1:0] front_hits_r, open_hits_r, far_count_r;
  logic [SW-1:0] side_sum_r, far_sum_r;
  logic          far_inf_r;
  logic          finite, inf, front_hit, open_hit, far_fin;
  logic [RW-1:0] side_add;
  logic [SW:0]   side_tot, far_tot;
  logic signed [RW+lss_pkg::TrigW:0] lo_lim, hi_lim;

  always_comb begin
    finite    = s3_st_r == lss_pkg::StFinite;
    inf       = s3_st_r == lss_pkg::StInf;
    lo_lim    = $signed({2'b00, range_min_r, 15'd0});
    hi_lim    = $signed({2'b00, front_thr_r, 15'd0});
    front_hit = s3_w_r[0] && finite && (p_front_r > lo_lim) && (p_front_r < hi_lim);
    side_add  = finite ? p_side_r[RW+14:15] : range_max_r;
    side_tot  = {1'b0, side_sum_r} + (SW+1)'(side_add);
    far_fin   = finite && (s3_r_r >= open_thr_r);
    open_hit  = s3_w_r[2] && ((finite && (s3_r_r < range_min_r)) || far_fin || inf);
    far_tot   = {1'b0, far_sum_r} + (SW+1)'(s3_r_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      front_hits_r <= '0;
      open_hits_r  <= '0;
      far_count_r  <= '0;
      side_sum_r   <= '0;
      far_sum_r    <= '0;
      far_inf_r    <= 1'b0;
    end else if (s3_v_r) begin
      if (front_hit && front_hits_r != lss_pkg::CntMax) front_hits_r <= front_hits_r + 1'b1;
      if (s3_w_r[1]) side_sum_r <= side_tot[SW] ? lss_pkg::SumMax : side_tot[SW-1:0];
      if (open_hit && open_hits_r != lss_pkg::CntMax) open_hits_r <= open_hits_r + 1'b1;
      if (s3_w_r[2] && (far_fin || inf)) begin
        if (far_count_r != lss_pkg::CntMax) far_count_r <= far_count_r + 1'b1;
        if (far_fin) far_sum_r <= far_tot[SW] ? lss_pkg::SumMax : far_tot[SW-1:0];
        else far_inf_r <= 1'b1;
      end
    end
  end

  // shared divider
  logic [SW-1:0] div_num, div_quot;
  logic [CW-1:0] div_den;
  logic          div_done;
  logic [15:0]   q16;
  logic [15:0]   res_r [4];

  always_comb begin
    case (cmd.div_sel)
      lss_pkg::SelFront: begin
        div_num = {front_hits_r, 16'd0};
        div_den = win_len(front_win_r);
      end
      lss_pkg::SelSide: begin
        div_num = side_sum_r;
        div_den = win_len(side_win_r);
      end
      lss_pkg::SelOpen: begin
        div_num = {open_hits_r, 16'd0};
        div_den = win_len(open_win_r);
      end
      default: begin
        div_num = far_sum_r;
        div_den = far_count_r;
      end
    endcase
    if (div_den == '0) q16 = '0;
    else if (|div_quot[SW-1:16]) q16 = 16'hFFFF;
    else q16 = div_quot[15:0];
  end

  lss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (div_done) res_r[cmd.div_sel] <= q16;
    if (cmd.load_out) begin
      out_front_fraction  <= res_r[lss_pkg::SelFront];
      out_side_mean       <= res_r[lss_pkg::SelSide];
      out_open_fraction   <= res_r[lss_pkg::SelOpen];
      out_open_mean       <= (far_count_r == '0) ? 16'd0 :
                             far_inf_r ? 16'hFFFF : res_r[lss_pkg::SelFar];
      out_open_mean_valid <= far_count_r != '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              last_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lss_pkg::lss_sts_t sts,
  output lss_pkg::lss_cmd_t      cmd
);

  typedef enum logic [1:0] {S_ACC, S_DRAIN, S_DIV, S_WAIT} state_t;

  state_t            state_r;
  logic              div_start_r, out_valid_r;
  lss_pkg::div_sel_t sel_r;
  logic              push, load;

  assign in_ready = state_r == S_ACC;
  assign push     = in_valid && in_ready;
  assign load     = (state_r == S_WAIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      div_start_r <= 1'b0;
      sel_r       <= lss_pkg::SelFront;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_ACC: begin
          if (push && last_in) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          // let the beam pipeline empty before dividing
          if (!sts.pipe_busy) begin
            sel_r       <= lss_pkg::SelFront;
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            if (sel_r == lss_pkg::SelFar) begin
              state_r <= S_WAIT;
            end else begin
              sel_r       <= sel_r + 1'b1;
              div_start_r <= 1'b1;
            end
          end
        end
        S_WAIT: begin
          if (load) state_r <= S_ACC;
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign cmd.push      = push;
  assign cmd.clear     = load;
  assign cmd.load_out  = load;
  assign cmd.div_start = div_start_r;
  assign cmd.div_sel   = sel_r;

endmodule
`default_nettype wire
